// ===== src/esd_pkg.sv =====
package esd_pkg;

	localparam int unsigned MAX_RES = 3;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_ONE       = 8'h31;
	localparam logic [7:0] CH_THREE     = 8'h33;
	localparam logic [7:0] CH_SEVEN     = 8'h37;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CH_LA        = 8'h61;
	localparam logic [7:0] CH_LB        = 8'h62;
	localparam logic [7:0] CH_LF        = 8'h66;
	localparam logic [7:0] CH_LN        = 8'h6E;
	localparam logic [7:0] CH_LR        = 8'h72;
	localparam logic [7:0] CH_LT        = 8'h74;
	localparam logic [7:0] CH_LV        = 8'h76;
	localparam logic [7:0] CH_LX        = 8'h78;
	localparam logic [7:0] CH_UA        = 8'h41;
	localparam logic [7:0] CH_UF        = 8'h46;

	localparam logic [7:0] CODE_NUL = 8'h00;
	localparam logic [7:0] CODE_BEL = 8'h07;
	localparam logic [7:0] CODE_BS  = 8'h08;
	localparam logic [7:0] CODE_FF  = 8'h0C;
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] CODE_TAB = 8'h09;
	localparam logic [7:0] CODE_VT  = 8'h0B;

	typedef enum logic [2:0] {
		MODE_PLAIN = 3'd0,
		MODE_ESC   = 3'd1,
		MODE_HEX0  = 3'd2,
		MODE_HEX1  = 3'd3,
		MODE_OCT1  = 3'd4,
		MODE_OCT2  = 3'd5
	} esd_mode_t;

	typedef logic [1:0] esd_cnt_t;

	typedef struct packed {
		esd_cnt_t                   cnt;
		logic [MAX_RES-1:0][7:0]    data;
		logic                       has_byte;
		logic                       last;
	} esd_bundle_t;

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
			(c >= CH_UA && c <= CH_UF);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		if (c <= CH_NINE) begin
			return c[3:0];
		end
		return c[3:0] + 4'd9;
	endfunction

	function automatic logic is_oct(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_SEVEN;
	endfunction

endpackage

// ===== src/esd_front.sv =====
module esd_front import esd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        enq,
	output esd_bundle_t bundle
);

	esd_mode_t  mode_q, mode_d;
	logic [7:0] first_q, first_d;
	logic [7:0] second_q, second_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			first_q  <= '0;
			second_q <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			first_q  <= first_d;
			second_q <= second_d;
		end
	end

	always_comb begin
		logic [MAX_RES-1:0][7:0] d;
		esd_cnt_t                n;
		logic                    ends;
		logic                    do_plain;
		d        = '0;
		n        = '0;
		mode_d   = mode_q;
		first_d  = first_q;
		second_d = second_q;
		do_plain = 1'b0;
		ends     = (in_byte == CODE_NUL) || in_last;

		if (in_byte != CODE_NUL) begin
			unique case (mode_q)
				MODE_ESC: begin
					mode_d = MODE_PLAIN;
					unique case (in_byte)
						CH_ZERO: begin d[n] = CODE_NUL; n = n + 2'd1; end
						CH_LA:   begin d[n] = CODE_BEL; n = n + 2'd1; end
						CH_LB:   begin d[n] = CODE_BS;  n = n + 2'd1; end
						CH_LF:   begin d[n] = CODE_FF;  n = n + 2'd1; end
						CH_LN:   begin d[n] = CODE_LF;  n = n + 2'd1; end
						CH_LR:   begin d[n] = CODE_CR;  n = n + 2'd1; end
						CH_LT:   begin d[n] = CODE_TAB; n = n + 2'd1; end
						CH_LV:   begin d[n] = CODE_VT;  n = n + 2'd1; end
						CH_LX:   mode_d = MODE_HEX0;
						default: begin
							if (in_byte >= CH_ONE && in_byte <= CH_THREE) begin
								first_d = in_byte;
								mode_d  = MODE_OCT1;
							end else begin
								d[n] = in_byte;
								n    = n + 2'd1;
							end
						end
					endcase
				end
				MODE_HEX0: begin
					if (is_hex(in_byte)) begin
						first_d = in_byte;
						mode_d  = MODE_HEX1;
					end else begin
						d[n] = CH_LX; n = n + 2'd1;
						do_plain = 1'b1;
					end
				end
				MODE_HEX1: begin
					if (is_hex(in_byte)) begin
						d[n]   = {hex_val(first_q), hex_val(in_byte)};
						n      = n + 2'd1;
						mode_d = MODE_PLAIN;
					end else begin
						d[n] = CH_LX;   n = n + 2'd1;
						d[n] = first_q; n = n + 2'd1;
						do_plain = 1'b1;
					end
				end
				MODE_OCT1: begin
					if (is_oct(in_byte)) begin
						second_d = in_byte;
						mode_d   = MODE_OCT2;
					end else begin
						d[n] = first_q; n = n + 2'd1;
						do_plain = 1'b1;
					end
				end
				MODE_OCT2: begin
					if (is_oct(in_byte)) begin
						d[n]   = {first_q[1:0], second_q[2:0], in_byte[2:0]};
						n      = n + 2'd1;
						mode_d = MODE_PLAIN;
					end else begin
						d[n] = first_q;  n = n + 2'd1;
						d[n] = second_q; n = n + 2'd1;
						do_plain = 1'b1;
					end
				end
				default: do_plain = 1'b1;
			endcase

			if (do_plain) begin
				if (in_byte == CH_BACKSLASH) begin
					mode_d = MODE_ESC;
				end else begin
					mode_d = MODE_PLAIN;
					d[n]   = in_byte;
					n      = n + 2'd1;
				end
			end
		end

		if (ends) begin
			unique case (mode_d)
				MODE_HEX0: begin d[n] = CH_LX; n = n + 2'd1; end
				MODE_HEX1: begin
					d[n] = CH_LX;   n = n + 2'd1;
					d[n] = first_d; n = n + 2'd1;
				end
				MODE_OCT1: begin d[n] = first_d; n = n + 2'd1; end
				MODE_OCT2: begin
					d[n] = first_d;  n = n + 2'd1;
					d[n] = second_d; n = n + 2'd1;
				end
				default: ;
			endcase
			mode_d   = MODE_PLAIN;
			first_d  = '0;
			second_d = '0;
		end

		bundle.data     = d;
		bundle.last     = ends;
		bundle.has_byte = 1'b1;
		bundle.cnt      = n;
		if (ends && n == '0) begin
			bundle.cnt      = 2'd1;
			bundle.has_byte = 1'b0;
		end
		enq = accept && (bundle.cnt != '0);
	end

endmodule

// ===== src/esd_queue.sv =====
module esd_queue import esd_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr,
	input  esd_bundle_t wr_data,
	output logic        full,
	input  logic        rd,
	output logic        nonempty,
	output esd_bundle_t rd_data
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	esd_bundle_t   mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rd_data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (wr && !full) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (rd && nonempty) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({wr && !full, rd && nonempty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== src/esd_back.sv =====
module esd_back import esd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_nonempty,
	input  esd_bundle_t q_data,
	output logic        q_rd,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        has_byte,
	output logic        out_last
);

	esd_bundle_t cur_q;
	esd_cnt_t    idx_q;
	logic        valid_q;
	logic        take;
	logic        done;
	logic        at_end;

	assign at_end   = (idx_q == cur_q.cnt - 2'd1);
	assign take     = pop && valid_q;
	assign done     = take && at_end;
	assign q_rd     = q_nonempty && (!valid_q || done);

	assign empty    = !valid_q;
	assign out_byte = cur_q.data[idx_q];
	assign has_byte = cur_q.has_byte;
	assign out_last = cur_q.last && at_end;

	always_ff @(posedge clk) begin
		if (q_rd) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (done) begin
			valid_q <= 1'b0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// ===== src/escape_sequence_decoder.sv =====
// Path: a byte accepted by the front end is written to the bundle queue, then loaded into
// the back end's output register before its first result is on the outputs.
// Throughput: one byte per cycle while the queue is not full and each byte gives at most
// one result; results leave one per cycle while pop is held, so a byte with several
// results holds the back end for one pop per result and the bundle queue (DEPTH) absorbs it.
// Reset: arst_n clears the parser to plain mode and empties the bundle queue and the back end.
module escape_sequence_decoder import esd_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       out_last
);

	esd_bundle_t front_bundle;
	esd_bundle_t q_data;
	logic        enq;
	logic        q_full;
	logic        q_rd;
	logic        q_nonempty;

	assign full = q_full;

	esd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (push && !q_full),
		.in_byte (in_byte),
		.in_last (in_last),
		.enq     (enq),
		.bundle  (front_bundle)
	);

	esd_queue #(.DEPTH(DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (enq),
		.wr_data  (front_bundle),
		.full     (q_full),
		.rd       (q_rd),
		.nonempty (q_nonempty),
		.rd_data  (q_data)
	);

	esd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_data     (q_data),
		.q_rd       (q_rd),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.has_byte   (has_byte),
		.out_last   (out_last)
	);

endmodule

// ===== test/escape_sequence_decoder_tb.sv =====
module escape_sequence_decoder_tb import esd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int NUM_DIRECTED = 36;

	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       lst;
	} dec_res_t;

	typedef struct packed {
		logic [7:0]          b;
		logic                l;
		logic                typed;
		logic [1:0]          n;
		dec_res_t [0:2]      r;
	} stim_row_t;

	localparam dec_res_t NO_RES = '0;
	localparam dec_res_t END_MARK = '{data: 8'h00, has: 1'b0, lst: 1'b1};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       out_last;

	esd_mode_t  dec_mode = MODE_PLAIN;
	logic [7:0] dec_first = 8'h00;
	logic [7:0] dec_second = 8'h00;
	dec_res_t   step_out[$];
	dec_res_t   decoded_q[$];
	stim_row_t  text_q[$];
	stim_row_t  directed_rows [NUM_DIRECTED];

	int    mismatch_cnt = 0;
	int    cycle_cnt = 0;
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	bit    hold_req = 1'b0;
	int    hold_left = 0;
	string hex_digits = "0123456789abcdefABCDEF";
	string simple_escapes = "0abfnrtv";

	escape_sequence_decoder i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.empty    (empty),
		.pop      (pop),
		.out_byte (out_byte),
		.has_byte (has_byte),
		.out_last (out_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic dec_res_t mid(input logic [7:0] d);
		return '{data: d, has: 1'b1, lst: 1'b0};
	endfunction

	function automatic dec_res_t fin(input logic [7:0] d);
		return '{data: d, has: 1'b1, lst: 1'b1};
	endfunction

	function automatic stim_row_t given(input logic [7:0] b, input logic l, input logic [1:0] n,
			input dec_res_t r0 = NO_RES, input dec_res_t r1 = NO_RES,
			input dec_res_t r2 = NO_RES);
		stim_row_t row;
		row.b = b;
		row.l = l;
		row.typed = 1'b1;
		row.n = n;
		row.r[0] = r0;
		row.r[1] = r1;
		row.r[2] = r2;
		return row;
	endfunction

	function automatic stim_row_t pred(input logic [7:0] b, input logic l = 1'b0);
		stim_row_t row;
		row = '0;
		row.b = b;
		row.l = l;
		return row;
	endfunction

	function automatic logic hex_char(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE], [CH_LA:CH_LF], [CH_UA:CH_UF]};
	endfunction

	function automatic logic [3:0] nibble(input logic [7:0] c);
		logic [7:0] v;
		if (c <= CH_NINE) begin
			v = c - CH_ZERO;
		end else if (c >= CH_LA) begin
			v = c - CH_LA + 8'd10;
		end else begin
			v = c - CH_UA + 8'd10;
		end
		return v[3:0];
	endfunction

	function automatic logic oct_char(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_SEVEN]};
	endfunction

	function automatic void put(input logic [7:0] d);
		step_out.push_back(mid(d));
	endfunction

	function automatic void take_plain(input logic [7:0] b);
		if (b == CH_BACKSLASH) begin
			dec_mode = MODE_ESC;
		end else begin
			dec_mode = MODE_PLAIN;
			put(b);
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic l);
		step_out.delete();
		if (b != 8'h00) begin
			case (dec_mode)
				MODE_ESC: begin
					dec_mode = MODE_PLAIN;
					case (b)
						CH_ZERO: put(CODE_NUL);
						CH_LA:   put(CODE_BEL);
						CH_LB:   put(CODE_BS);
						CH_LF:   put(CODE_FF);
						CH_LN:   put(CODE_LF);
						CH_LR:   put(CODE_CR);
						CH_LT:   put(CODE_TAB);
						CH_LV:   put(CODE_VT);
						CH_LX:   dec_mode = MODE_HEX0;
						default: begin
							if (b >= CH_ONE && b <= CH_THREE) begin
								dec_first = b;
								dec_mode = MODE_OCT1;
							end else begin
								put(b);
							end
						end
					endcase
				end
				MODE_HEX0: begin
					if (hex_char(b)) begin
						dec_first = b;
						dec_mode = MODE_HEX1;
					end else begin
						put(CH_LX);
						take_plain(b);
					end
				end
				MODE_HEX1: begin
					if (hex_char(b)) begin
						put({nibble(dec_first), nibble(b)});
						dec_mode = MODE_PLAIN;
					end else begin
						put(CH_LX);
						put(dec_first);
						take_plain(b);
					end
				end
				MODE_OCT1: begin
					if (oct_char(b)) begin
						dec_second = b;
						dec_mode = MODE_OCT2;
					end else begin
						put(dec_first);
						take_plain(b);
					end
				end
				MODE_OCT2: begin
					if (oct_char(b)) begin
						put({dec_first[1:0], dec_second[2:0], b[2:0]});
						dec_mode = MODE_PLAIN;
					end else begin
						put(dec_first);
						put(dec_second);
						take_plain(b);
					end
				end
				default: take_plain(b);
			endcase
		end
		if (b == 8'h00 || l) begin
			case (dec_mode)
				MODE_HEX0: put(CH_LX);
				MODE_HEX1: begin
					put(CH_LX);
					put(dec_first);
				end
				MODE_OCT1: put(dec_first);
				MODE_OCT2: begin
					put(dec_first);
					put(dec_second);
				end
				default: ;
			endcase
			dec_mode = MODE_PLAIN;
			dec_first = 8'h00;
			dec_second = 8'h00;
			if (step_out.size() == 0) begin
				step_out.push_back(END_MARK);
			end else begin
				step_out[step_out.size() - 1].lst = 1'b1;
			end
		end
	endfunction

	function automatic void note_mismatch(input string what, input dec_res_t want);
		mismatch_cnt++;
		if (mismatch_cnt <= 10) begin
			$display("%0t: %s: expected byte %h has %b last %b, got byte %h has %b last %b",
				$realtime, what, want.data, want.has, want.lst, out_byte, has_byte, out_last);
		end
	endfunction

	task automatic send_row(input stim_row_t row);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		in_byte <= row.b;
		in_last <= row.l;
		do @(posedge clk); while (full);
		decode_byte(row.b, row.l);
		if (row.typed) begin
			for (int k = 0; k < row.n; k++) begin
				decoded_q.push_back(row.r[k]);
			end
		end else begin
			foreach (step_out[k]) begin
				decoded_q.push_back(step_out[k]);
			end
		end
	endtask

	function automatic void add_text(input logic [7:0] b);
		stim_row_t row;
		row = pred(b, $urandom_range(99) < 3);
		text_q.push_back(row);
	endfunction

	function automatic logic [7:0] any_nonzero();
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic void gen_sequence();
		int runlen;
		case ($urandom_range(9))
			0, 1: begin
				runlen = $urandom_range(1, 4);
				repeat (runlen) add_text(any_nonzero());
			end
			2: begin
				add_text(CH_BACKSLASH);
				if ($urandom_range(3) == 0) begin
					add_text(any_nonzero());
				end else begin
					add_text(simple_escapes[$urandom_range(7)]);
				end
			end
			3: begin
				add_text(CH_BACKSLASH);
				add_text(CH_LX);
				add_text(hex_digits[$urandom_range(21)]);
				add_text(hex_digits[$urandom_range(21)]);
			end
			4: begin
				add_text(CH_BACKSLASH);
				add_text(CH_LX);
				if ($urandom_range(1)) begin
					add_text(hex_digits[$urandom_range(21)]);
				end
				add_text(any_nonzero());
			end
			5: begin
				add_text(CH_BACKSLASH);
				add_text(CH_ONE + 8'($urandom_range(2)));
				add_text(CH_ZERO + 8'($urandom_range(7)));
				add_text(CH_ZERO + 8'($urandom_range(7)));
			end
			6: begin
				add_text(CH_BACKSLASH);
				add_text(CH_ONE + 8'($urandom_range(2)));
				add_text(any_nonzero());
				if ($urandom_range(1)) begin
					add_text(any_nonzero());
				end
			end
			7: add_text(8'h00);
			8: add_text(8'($urandom_range(255)));
			default: begin
				add_text(CH_BACKSLASH);
				case ($urandom_range(3))
					0: ;
					1: add_text(CH_LX);
					2: begin
						add_text(CH_LX);
						add_text(hex_digits[$urandom_range(21)]);
					end
					default: add_text(CH_ONE + 8'($urandom_range(2)));
				endcase
				text_q[text_q.size() - 1].l = 1'b1;
			end
		endcase
	endfunction

	task automatic gen_text(input int target);
		int sent;
		sent = 0;
		while (sent < target) begin
			text_q.delete();
			gen_sequence();
			foreach (text_q[k]) begin
				send_row(text_q[k]);
			end
			sent += text_q.size();
		end
	endtask

	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		dec_res_t want;
		if (arst_n && pop && !empty) begin
			if (decoded_q.size() == 0) begin
				note_mismatch("beat with nothing expected", NO_RES);
			end else begin
				want = decoded_q.pop_front();
				if (out_byte !== want.data || has_byte !== want.has || out_last !== want.lst) begin
					note_mismatch("wrong beat", want);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		directed_rows = '{
			given(CH_BACKSLASH, 1'b0, 2'd0),
			given(CH_LN, 1'b0, 2'd1, mid(CODE_LF)),
			pred(CH_BACKSLASH), pred(CH_LA),
			pred(CH_BACKSLASH), pred(CH_LB),
			pred(CH_BACKSLASH), pred(CH_LF),
			pred(CH_BACKSLASH), pred(CH_LR),
			pred(CH_BACKSLASH), pred(CH_LT),
			pred(CH_BACKSLASH), pred(CH_LV),
			pred(CH_BACKSLASH), pred(CH_LX), pred(CH_UF),
			given(CH_LF, 1'b0, 2'd1, mid(8'hFF)),
			given(CH_BACKSLASH, 1'b0, 2'd0),
			given(CH_ZERO, 1'b0, 2'd1, mid(CODE_NUL)),
			pred(CH_ONE), pred("2"),
			pred(CH_BACKSLASH), pred(CH_LX),
			given("g", 1'b0, 2'd2, mid(CH_LX), mid("g")),
			pred(CH_BACKSLASH), pred(CH_THREE), pred(CH_SEVEN),
			given(CH_SEVEN, 1'b1, 2'd1, fin(8'hFF)),
			pred(CH_BACKSLASH), pred("2"), pred("5"),
			given("9", 1'b1, 2'd3, mid("2"), mid("5"), fin("9")),
			given(CH_BACKSLASH, 1'b1, 2'd1, END_MARK),
			given(8'h00, 1'b0, 2'd1, END_MARK),
			given(8'hFF, 1'b0, 2'd1, mid(8'hFF))
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[k]) begin
			send_row(directed_rows[k]);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 65;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 65;
				end
				default: begin
					send_idle_pct = 10;
					recv_stall_pct = 10;
				end
			endcase
			gen_text(95);
		end

		// hold the receiver off while the sender keeps pushing
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b1;
		gen_text(40);

		@(negedge clk);
		push <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_cnt == 0 && decoded_q.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/esd_pkg.sv
src/esd_front.sv
src/esd_queue.sv
src/esd_back.sv
src/escape_sequence_decoder.sv
test/escape_sequence_decoder_tb.sv
